// ===== hw/rtl/luma_weighted_film_grain_unit_macros.svh =====
// -----------------------------------------------------------------------------
// luma_weighted_film_grain_unit_macros.svh
// Assertion macros used by the film grain checker.
// -----------------------------------------------------------------------------
`ifndef LUMA_WEIGHTED_FILM_GRAIN_UNIT_MACROS_SVH
`define LUMA_WEIGHTED_FILM_GRAIN_UNIT_MACROS_SVH

// same-cycle implication, masked during reset
`define LWFG_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, masked during reset
`define LWFG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication, live during reset
`define LWFG_ASSERT_NEXT_RST(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/lwfg_pkg.sv =====
// -----------------------------------------------------------------------------
// lwfg_pkg
// Constants, register codes and the quarter-wave sine table of the film grain unit.
// -----------------------------------------------------------------------------
package lwfg_pkg;

  localparam int COORD_BITS       = 12;
  localparam int SINE_TABLE_DEPTH = 1024;
  localparam int SINE_BITS        = $clog2(SINE_TABLE_DEPTH);
  localparam int QTR_DEPTH        = SINE_TABLE_DEPTH / 4;
  localparam int QIDX_W           = SINE_BITS - 1;

  localparam int SEED_BITS = 16;
  localparam int ACC_W     = ((COORD_BITS > SEED_BITS) ? COORD_BITS : SEED_BITS) + 1;

  // cell origin: floor(x / gs) by reciprocal, exact for x < 2^COORD_BITS, gs < 16
  localparam int DIV_SHIFT = COORD_BITS + 4;
  localparam int RECIP_W   = DIV_SHIFT + 1;
  typedef logic [RECIP_W-1:0] recip_t;
  localparam recip_t GS_RECIP [16] = '{
    RECIP_W'((64'd1 << DIV_SHIFT) / 1),
    RECIP_W'((64'd1 << DIV_SHIFT) / 1),
    RECIP_W'(((64'd1 << DIV_SHIFT) + 1) / 2),
    RECIP_W'(((64'd1 << DIV_SHIFT) + 2) / 3),
    RECIP_W'(((64'd1 << DIV_SHIFT) + 3) / 4),
    RECIP_W'(((64'd1 << DIV_SHIFT) + 4) / 5),
    RECIP_W'(((64'd1 << DIV_SHIFT) + 5) / 6),
    RECIP_W'(((64'd1 << DIV_SHIFT) + 6) / 7),
    RECIP_W'(((64'd1 << DIV_SHIFT) + 7) / 8),
    RECIP_W'(((64'd1 << DIV_SHIFT) + 8) / 9),
    RECIP_W'(((64'd1 << DIV_SHIFT) + 9) / 10),
    RECIP_W'(((64'd1 << DIV_SHIFT) + 10) / 11),
    RECIP_W'(((64'd1 << DIV_SHIFT) + 11) / 12),
    RECIP_W'(((64'd1 << DIV_SHIFT) + 12) / 13),
    RECIP_W'(((64'd1 << DIV_SHIFT) + 13) / 14),
    RECIP_W'(((64'd1 << DIV_SHIFT) + 14) / 15)
  };

  // phase constants, Q16
  localparam longint unsigned PHASE_KX   = 64'd851300;
  localparam longint unsigned PHASE_KY   = 64'd5127078;
  localparam longint unsigned TWO_PI_Q16 = 64'd411775;
  localparam int M_W  = 19;
  localparam int KR_W = 18;
  localparam logic [KR_W-1:0] KX_RED = KR_W'(PHASE_KX % TWO_PI_Q16);
  localparam logic [KR_W-1:0] KY_RED = KR_W'(PHASE_KY % TWO_PI_Q16);
  localparam logic [M_W-1:0]  TWO_PI = M_W'(TWO_PI_Q16);
  localparam int PH_W = ACC_W + KR_W + 1;

  // phase mod 2pi: estimate from the top bits, then fix up by up to 3*2pi
  localparam int MOD_T_W     = 18;
  localparam int MOD_SHIFT   = PH_W - MOD_T_W;
  localparam int EST_SHIFT   = PH_W + 1 - MOD_SHIFT;
  localparam int EST_W       = MOD_T_W;
  localparam int MOD_RECIP_W = 20;
  localparam logic [MOD_RECIP_W-1:0] MOD_RECIP =
    MOD_RECIP_W'((64'd1 << (PH_W + 1)) / TWO_PI_Q16);
  localparam int RR_W = M_W + 2;

  // table index: floor(rem * DEPTH / 2pi), estimate then one correction
  localparam int IDX_SHIFT   = 29;
  localparam int IDX_RECIP_W = SINE_BITS + 11;
  localparam logic [IDX_RECIP_W-1:0] IDX_RECIP =
    IDX_RECIP_W'((64'd1 << (IDX_SHIFT + SINE_BITS)) / TWO_PI_Q16);

  // hash
  localparam logic [30:0] HASH_K31 = 31'(64'd2867760025);

  // grain: divide by 100 via reciprocal
  localparam int GRAIN_SHIFT   = 29;
  localparam int GRAIN_RECIP_W = 23;
  localparam logic [GRAIN_RECIP_W-1:0] GRAIN_RECIP =
    GRAIN_RECIP_W'(((64'd1 << GRAIN_SHIFT) + 99) / 100);
  localparam logic [6:0] IP_MAX = 7'd100;
  localparam logic signed [15:0] H_MID = 16'sd16384;

  // luma
  localparam logic [17:0] LUMA_KR  = 18'd299;
  localparam logic [17:0] LUMA_KG  = 18'd587;
  localparam logic [17:0] LUMA_KB  = 18'd114;
  localparam logic [17:0] LUMA_MID = 18'd128000;

  // register reset values
  localparam logic [6:0]  RST_INTENSITY = 7'd50;
  localparam logic [3:0]  RST_GRAIN     = 4'd2;
  localparam logic [3:0]  GRAIN_MIN     = 4'd1;

  typedef enum logic [1:0] {
    REG_INTENSITY = 2'd0,
    REG_GRAIN     = 2'd1,
    REG_ANIMATE   = 2'd2,
    REG_SEED      = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       dark;
  } pix_t;

  // quarter-wave sine, Q1.15, entries 0..QTR_DEPTH
  typedef logic signed [15:0] sine_qtr_t [QTR_DEPTH+1];
  localparam longint unsigned TAYLOR_DIV [5] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110};
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  function automatic sine_qtr_t build_sine_qtr();
    sine_qtr_t       tab;
    longint unsigned f;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned v;
    longint          sum;
    for (int j = 0; j <= QTR_DEPTH; j++) begin
      f    = longint'(j) << (32 - SINE_BITS);
      x    = (f * HALF_PI_Q30) >> 30;
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      for (int k = 0; k < 5; k++) begin
        term = ((term * x2) >> 30) / TAYLOR_DIV[k];
        if ((k % 2) == 0) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      v = (unsigned'(sum) + 64'd16384) >> 15;
      if (v > 64'd32767) begin
        v = 64'd32767;
      end
      tab[j] = 16'(v);
    end
    return tab;
  endfunction

  localparam sine_qtr_t SINE_QTR = build_sine_qtr();

endpackage

// ===== hw/rtl/luma_weighted_film_grain_unit.sv =====
// -----------------------------------------------------------------------------
// luma_weighted_film_grain_unit
// Per-pixel film grain from a sine hash of the grain cell, weighted by luma.
// -----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one pixel per item: x_pos,
//   y_pos and the three 8-bit channels. Output channel (out_valid /
//   out_stall) carries red_out, green_out, blue_out, one item per input item,
//   in order.
//   Throughput: one item per clock while out_stall does not hold the output.
//   The 15 register stages lie between acceptance and out_valid (cell
//   origin, phase products, mod 2pi estimate and fix-up, table index, sine
//   lookup, hash, grain divide, luma halving, channel multiply).
//   Stall: the whole pipeline freezes while the output item is held by
//   out_stall; in_stall is raised for exactly those cycles. Bubbles travel
//   as cleared valid bits.
//   Reset (rst, synchronous): all stage valid bits clear, registers return to
//   intensity 50, grain size 2, animation off, seed 0. The sine table is
//   constant logic and needs no fill.
//   Configuration (cfg_we, cfg_index, cfg_data) must be written only while idle; the block does not enforce this.
// -----------------------------------------------------------------------------
module luma_weighted_film_grain_unit (
  input  logic                              clk,
  input  logic                              rst,
  // configuration
  input  logic                              cfg_we,
  input  logic [1:0]                        cfg_index,
  input  logic [15:0]                       cfg_data,
  // input items
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [lwfg_pkg::COORD_BITS-1:0]   x_pos,
  input  logic [lwfg_pkg::COORD_BITS-1:0]   y_pos,
  input  logic [7:0]                        red_in,
  input  logic [7:0]                        green_in,
  input  logic [7:0]                        blue_in,
  // result items
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [7:0]                        red_out,
  output logic [7:0]                        green_out,
  output logic [7:0]                        blue_out
);

  localparam int CB = lwfg_pkg::COORD_BITS;
  localparam int SB = lwfg_pkg::SINE_BITS;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [6:0]  intensity_percent;
  logic [3:0]  grain_size;
  logic        animate_enable;
  logic [15:0] frame_seed;

  always_ff @(posedge clk) begin
    if (rst) begin
      intensity_percent <= lwfg_pkg::RST_INTENSITY;
      grain_size        <= lwfg_pkg::RST_GRAIN;
      animate_enable    <= 1'b0;
      frame_seed        <= '0;
    end else if (cfg_we) begin
      case (lwfg_pkg::cfg_reg_t'(cfg_index))
        lwfg_pkg::REG_INTENSITY: intensity_percent <= cfg_data[6:0];
        lwfg_pkg::REG_GRAIN:     grain_size        <= cfg_data[3:0];
        lwfg_pkg::REG_ANIMATE:   animate_enable    <= cfg_data[0];
        lwfg_pkg::REG_SEED:      frame_seed        <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [3:0]  gs_eff;
  logic [15:0] seed;
  logic [6:0]  ip_sat;

  assign gs_eff = (grain_size == '0) ? lwfg_pkg::GRAIN_MIN : grain_size;
  assign seed   = animate_enable ? frame_seed : '0;
  assign ip_sat = (intensity_percent > lwfg_pkg::IP_MAX) ? lwfg_pkg::IP_MAX
                                                         : intensity_percent;

  // ---------------------------------------------------------------------------
  // Pipeline control: global enable, frozen while the output item is held
  // ---------------------------------------------------------------------------
  logic        en;
  logic [15:1] vld;

  assign en       = !(vld[15] && out_stall);
  assign in_stall = !en;
  assign out_valid = vld[15];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[14:1], in_valid};
    end
  end

  // pixel and dark flag travel beside the hash; entry k belongs to stage k+1
  lwfg_pkg::pix_t pix_q [14];
  lwfg_pkg::pix_t pix_in;
  logic [17:0]    luma;

  assign luma = 18'(red_in) * lwfg_pkg::LUMA_KR + 18'(green_in) * lwfg_pkg::LUMA_KG
              + 18'(blue_in) * lwfg_pkg::LUMA_KB;

  always_comb begin
    pix_in.red   = red_in;
    pix_in.green = green_in;
    pix_in.blue  = blue_in;
    pix_in.dark  = (luma <= lwfg_pkg::LUMA_MID);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pix_q[0] <= pix_in;
      for (int k = 1; k < 14; k++) begin
        pix_q[k] <= pix_q[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: cell index = floor(coord / gs) by reciprocal multiply
  // ---------------------------------------------------------------------------
  logic [CB+lwfg_pkg::RECIP_W-1:0] xq_prod, yq_prod;
  logic [CB-1:0]                   qx, qy;

  assign xq_prod = (CB+lwfg_pkg::RECIP_W)'(x_pos) *
                   (CB+lwfg_pkg::RECIP_W)'(lwfg_pkg::GS_RECIP[grain_size]);
  assign yq_prod = (CB+lwfg_pkg::RECIP_W)'(y_pos) *
                   (CB+lwfg_pkg::RECIP_W)'(lwfg_pkg::GS_RECIP[grain_size]);

  always_ff @(posedge clk) begin
    if (en) begin
      qx <= xq_prod[lwfg_pkg::DIV_SHIFT +: CB];
      qy <= yq_prod[lwfg_pkg::DIV_SHIFT +: CB];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: cell origin plus seed
  // ---------------------------------------------------------------------------
  logic [lwfg_pkg::ACC_W-1:0] ax, ay;

  always_ff @(posedge clk) begin
    if (en) begin
      ax <= lwfg_pkg::ACC_W'(qx * gs_eff) + lwfg_pkg::ACC_W'(seed);
      ay <= lwfg_pkg::ACC_W'(qy * gs_eff) + lwfg_pkg::ACC_W'(seed);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3/4: phase products with constants already reduced mod 2pi, then sum
  // ---------------------------------------------------------------------------
  logic [lwfg_pkg::PH_W-1:0] px, py, vsum;

  always_ff @(posedge clk) begin
    if (en) begin
      px   <= lwfg_pkg::PH_W'(ax) * lwfg_pkg::PH_W'(lwfg_pkg::KX_RED);
      py   <= lwfg_pkg::PH_W'(ay) * lwfg_pkg::PH_W'(lwfg_pkg::KY_RED);
      vsum <= px + py;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5..7: phase mod 2pi (quotient estimate, remainder, fix-up)
  // ---------------------------------------------------------------------------
  localparam int EPW = lwfg_pkg::MOD_T_W + lwfg_pkg::MOD_RECIP_W;

  logic [EPW-1:0]                 est_prod;
  logic [lwfg_pkg::EST_W-1:0]     est;
  logic [lwfg_pkg::PH_W-1:0]      v5;
  logic [lwfg_pkg::PH_W-1:0]      est_m;
  logic [lwfg_pkg::PH_W-1:0]      diff;
  logic [lwfg_pkg::RR_W-1:0]      rraw;
  logic [lwfg_pkg::RR_W-1:0]      m1, m2, m3;
  logic [lwfg_pkg::M_W-1:0]       rem_next, rem;

  assign est_prod = EPW'(vsum[lwfg_pkg::PH_W-1 -: lwfg_pkg::MOD_T_W]) *
                    EPW'(lwfg_pkg::MOD_RECIP);
  assign est_m    = lwfg_pkg::PH_W'(est) * lwfg_pkg::PH_W'(lwfg_pkg::TWO_PI);
  assign diff     = v5 - est_m;

  assign m1 = lwfg_pkg::RR_W'(lwfg_pkg::TWO_PI);
  assign m2 = lwfg_pkg::RR_W'(lwfg_pkg::TWO_PI) << 1;
  assign m3 = m1 + m2;

  always_comb begin
    if (rraw >= m3) begin
      rem_next = lwfg_pkg::M_W'(rraw - m3);
    end else if (rraw >= m2) begin
      rem_next = lwfg_pkg::M_W'(rraw - m2);
    end else if (rraw >= m1) begin
      rem_next = lwfg_pkg::M_W'(rraw - m1);
    end else begin
      rem_next = lwfg_pkg::M_W'(rraw);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      est  <= est_prod[lwfg_pkg::EST_SHIFT +: lwfg_pkg::EST_W];
      v5   <= vsum;
      rraw <= diff[lwfg_pkg::RR_W-1:0];
      rem  <= rem_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 8/9: table index = floor(rem * DEPTH / 2pi)
  // ---------------------------------------------------------------------------
  localparam int IPW = lwfg_pkg::M_W + lwfg_pkg::IDX_RECIP_W;
  localparam int EW  = lwfg_pkg::M_W + SB;

  logic [IPW-1:0] ie_prod;
  logic [SB-1:0]  ie;
  logic [lwfg_pkg::M_W-1:0] rem8;
  logic [EW-1:0]  ie_m, e_rem;
  logic [SB:0]    idx_sum;
  logic [SB-1:0]  idx_next, idx;

  assign ie_prod = IPW'(rem) * IPW'(lwfg_pkg::IDX_RECIP);
  assign ie_m    = EW'(ie) * EW'(lwfg_pkg::TWO_PI);
  assign e_rem   = {rem8, {SB{1'b0}}} - ie_m;

  always_comb begin
    idx_sum = {1'b0, ie} + ((e_rem >= EW'(lwfg_pkg::TWO_PI)) ? (SB+1)'(1) : '0);
    if (idx_sum[SB]) begin
      idx_next = '1;
    end else begin
      idx_next = idx_sum[SB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ie   <= ie_prod[lwfg_pkg::IDX_SHIFT +: SB];
      rem8 <= rem;
      idx  <= idx_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 10: sine lookup
  // ---------------------------------------------------------------------------
  logic signed [15:0] sn;

  lwfg_sine_rom u_sine (
    .clk (clk),
    .en  (en),
    .idx (idx),
    .sn  (sn)
  );

  // ---------------------------------------------------------------------------
  // Stage 11: hash, fract(sn * 43758.5453) in Q31, keep Q15
  // ---------------------------------------------------------------------------
  logic [30:0] sn_ext;
  logic [61:0] hash_prod;
  logic [14:0] h;

  assign sn_ext    = {{15{sn[15]}}, sn};
  assign hash_prod = 62'(sn_ext) * 62'(lwfg_pkg::HASH_K31);

  always_ff @(posedge clk) begin
    if (en) begin
      h <= hash_prod[30:16];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 12/13: g = trunc((h - 0.5) * 2 * ip / 100)
  // ---------------------------------------------------------------------------
  localparam int GPW = 22 + lwfg_pkg::GRAIN_RECIP_W;

  logic signed [15:0] hd;
  logic signed [23:0] dprod;
  logic signed [24:0] d2;
  logic [21:0]        dmag;
  logic [GPW-1:0]     gq_prod;
  logic [15:0]        gq;
  logic signed [16:0] g_next, g;

  assign hd      = $signed({1'b0, h}) - lwfg_pkg::H_MID;
  assign d2      = 25'(dprod) <<< 1;
  assign dmag    = dprod[23] ? 22'(-d2) : 22'(d2);
  assign gq_prod = GPW'(dmag) * GPW'(lwfg_pkg::GRAIN_RECIP);
  assign gq      = gq_prod[lwfg_pkg::GRAIN_SHIFT +: 16];
  assign g_next  = dprod[23] ? -$signed({1'b0, gq}) : $signed({1'b0, gq});

  always_ff @(posedge clk) begin
    if (en) begin
      dprod <= 24'(hd) * 24'($signed({1'b0, ip_sat}));
      g     <= g_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 14: halve in dark pixels (floor), factor = 1 + g in Q15
  // ---------------------------------------------------------------------------
  logic signed [16:0] gh;
  logic signed [17:0] fsum;
  logic [16:0]        factor;

  assign gh   = pix_q[12].dark ? (g >>> 1) : g;
  assign fsum = 18'sd32768 + 18'(gh);

  always_ff @(posedge clk) begin
    if (en) begin
      factor <= fsum[16:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 15: scale channels, truncate, clamp at 255
  // ---------------------------------------------------------------------------
  logic [24:0] pr, pg, pb;

  assign pr = 25'(pix_q[13].red)   * 25'(factor);
  assign pg = 25'(pix_q[13].green) * 25'(factor);
  assign pb = 25'(pix_q[13].blue)  * 25'(factor);

  always_ff @(posedge clk) begin
    if (en) begin
      red_out   <= (pr[24:23] != '0) ? 8'hFF : pr[22:15];
      green_out <= (pg[24:23] != '0) ? 8'hFF : pg[22:15];
      blue_out  <= (pb[24:23] != '0) ? 8'hFF : pb[22:15];
    end
  end

endmodule

// ===== hw/rtl/lwfg_sine_rom.sv =====
// -----------------------------------------------------------------------------
// lwfg_sine_rom
// Registered full-wave sine lookup built on a quarter-wave constant table.
// -----------------------------------------------------------------------------
module lwfg_sine_rom (
  input  logic                               clk,
  input  logic                               en,
  input  logic [lwfg_pkg::SINE_BITS-1:0]     idx,
  output logic signed [15:0]                 sn
);

  logic [1:0]                      quad;
  logic [lwfg_pkg::SINE_BITS-3:0]  pos;
  logic [lwfg_pkg::QIDX_W-1:0]     qi;
  logic signed [15:0]              val;

  assign quad = idx[lwfg_pkg::SINE_BITS-1 -: 2];
  assign pos  = idx[lwfg_pkg::SINE_BITS-3:0];

  // odd quadrants run the table backwards
  always_comb begin
    if (quad[0]) begin
      qi = lwfg_pkg::QIDX_W'(lwfg_pkg::QTR_DEPTH) - {1'b0, pos};
    end else begin
      qi = {1'b0, pos};
    end
    val = lwfg_pkg::SINE_QTR[qi];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sn <= quad[1] ? -val : val;
    end
  end

endmodule

// ===== hw/rtl/lwfg_checker.sv =====
// -----------------------------------------------------------------------------
// lwfg_checker
// Port-level checks of the film grain unit, bound to the top level.
// -----------------------------------------------------------------------------
`include "luma_weighted_film_grain_unit_macros.svh"

module lwfg_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] red_out,
  input logic [7:0] green_out,
  input logic [7:0] blue_out
);

  // held result stays put
  `LWFG_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(red_out) && $stable(green_out) && $stable(blue_out), "held item changed")

  // input only backs up when a finished item is held
  `LWFG_ASSERT_IMP(a_stall_cause, in_stall, out_valid && out_stall, "input stalled without held output")

  // a taken output frees the pipeline
  `LWFG_ASSERT_IMP(a_flow, !out_valid || !out_stall, !in_stall, "input stalled while output flows")

  // reset empties the pipeline
  `LWFG_ASSERT_NEXT_RST(a_reset, rst, !out_valid, "output valid after reset")

endmodule

bind luma_weighted_film_grain_unit lwfg_checker u_lwfg_checker (.*);
